>>> design/bdeq_pkg.sv
package bdeq_pkg;

   // Capacity of the deque in words.
   localparam int DEPTH = 32;

   localparam int WORD_W = 32;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int OCC_W  = 6;

   typedef enum logic [1:0] {
      OP_PUSH_FRONT = 2'd0,
      OP_PUSH_REAR  = 2'd1,
      OP_POP_FRONT  = 2'd2,
      OP_POP_REAR   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic {
      CTRL_IDLE = 1'b0,
      CTRL_RESP = 1'b1
   } state_type;

   typedef struct packed {
      logic load;
      logic respond;
   } ctrl_cmd_type;

   // Adds an offset below DEPTH to a slot index and wraps the sum into range.
   function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] offset);
      logic [CNT_W:0] sum;
      sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(offset);
      if (sum >= (CNT_W + 1)'(DEPTH)) begin
         sum = sum - (CNT_W + 1)'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

>>> design/bounded_double_ended_queue.sv
// A transaction accepted at one clock edge has its result strobed during the following
// cycle, set by the registered read port of the slot memory.
// No new transaction is accepted while busy is high during the response cycle.
// Results cannot be stalled: rsp_strobe is high for exactly one cycle per transaction.
// Reset (synchronous, active high) empties the deque and returns the controller to idle;
// the slot memory is not cleared and needs no clearing pass.
module bounded_double_ended_queue (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_func,
   input  logic signed [bdeq_pkg::WORD_W-1:0]  req_value,
   output logic                                rsp_strobe,
   output logic signed [bdeq_pkg::WORD_W-1:0]  rsp_popped,
   output logic [1:0]                          rsp_status,
   output logic [bdeq_pkg::OCC_W-1:0]          rsp_occupancy
);

   // The controller sequences each transaction: the accept edge commits pointer and
   // count updates and launches the memory write or read; the next cycle presents
   // the result.
   bdeq_pkg::ctrl_cmd_type cmd;

   bdeq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   // The datapath holds the head index and element count of the circular store,
   // works out the slot each operation touches, and owns the slot memory.
   // A push into a full deque or a pop from an empty one leaves everything unchanged
   // and only reports its status.
   bdeq_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_func      (req_func),
      .req_value     (req_value),
      .rsp_popped    (rsp_popped),
      .rsp_status    (rsp_status),
      .rsp_occupancy (rsp_occupancy)
   );

   assign rsp_strobe = cmd.respond;

`ifndef SYNTHESIS
   a_strobe_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobed outside the response cycle");

   a_accept_then_strobe: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> rsp_strobe)
      else $error("accepted transaction produced no result");
`endif

endmodule

>>> design/bdeq_ram.sv
module bdeq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/bdeq_ctrl.sv
module bdeq_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   output bdeq_pkg::ctrl_cmd_type  cmd
);

   bdeq_pkg::state_type state_ff;
   bdeq_pkg::state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bdeq_pkg::CTRL_IDLE: begin
            if (start) begin
               state_in = bdeq_pkg::CTRL_RESP;
            end
         end
         bdeq_pkg::CTRL_RESP: begin
            state_in = bdeq_pkg::CTRL_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd.load    = 1'b0;
      cmd.respond = 1'b0;
      busy        = 1'b0;
      unique case (state_ff)
         bdeq_pkg::CTRL_IDLE: begin
            cmd.load = start;
         end
         bdeq_pkg::CTRL_RESP: begin
            cmd.respond = 1'b1;
            busy        = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bdeq_pkg::CTRL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   a_load_then_respond: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> cmd.respond)
      else $error("accepted transaction was not answered in the next cycle");

   a_single_response: assert property (@(posedge clock) disable iff (reset)
      cmd.respond |=> !cmd.respond)
      else $error("response strobe held for more than one cycle");
`endif

endmodule

>>> design/bdeq_dp.sv
module bdeq_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  bdeq_pkg::ctrl_cmd_type              cmd,
   input  logic [1:0]                          req_func,
   input  logic signed [bdeq_pkg::WORD_W-1:0]  req_value,
   output logic signed [bdeq_pkg::WORD_W-1:0]  rsp_popped,
   output logic [1:0]                          rsp_status,
   output logic [bdeq_pkg::OCC_W-1:0]          rsp_occupancy
);

   logic [bdeq_pkg::IDX_W-1:0] head_ff;
   logic [bdeq_pkg::IDX_W-1:0] head_in;
   logic [bdeq_pkg::CNT_W-1:0] count_ff;
   logic [bdeq_pkg::CNT_W-1:0] count_in;
   bdeq_pkg::status_type       status_ff;
   bdeq_pkg::status_type       status_in;
   logic                       pop_ok_ff;
   logic                       pop_ok_in;

   bdeq_pkg::op_type           op;
   logic                       full;
   logic                       empty;
   logic [bdeq_pkg::IDX_W-1:0] head_dec;
   logic [bdeq_pkg::IDX_W-1:0] head_inc;
   logic [bdeq_pkg::IDX_W-1:0] rear_next;
   logic [bdeq_pkg::IDX_W-1:0] rear_last;
   logic                       wr_req;
   logic [bdeq_pkg::IDX_W-1:0] wr_addr;
   logic [bdeq_pkg::IDX_W-1:0] rd_addr;
   logic [bdeq_pkg::WORD_W-1:0] rd_data;

   assign op    = bdeq_pkg::op_type'(req_func);
   assign full  = (count_ff == bdeq_pkg::CNT_W'(bdeq_pkg::DEPTH));
   assign empty = (count_ff == '0);

   assign head_dec  = (head_ff == '0) ? bdeq_pkg::IDX_W'(bdeq_pkg::DEPTH - 1)
                                      : head_ff - 1'b1;
   assign head_inc  = bdeq_pkg::wrap_add(head_ff, bdeq_pkg::CNT_W'(1));
   assign rear_next = bdeq_pkg::wrap_add(head_ff, count_ff);
   assign rear_last = bdeq_pkg::wrap_add(head_ff, count_ff - 1'b1);

   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      status_in = bdeq_pkg::ST_DONE;
      pop_ok_in = 1'b0;
      wr_req    = 1'b0;
      wr_addr   = head_ff;
      rd_addr   = head_ff;
      unique case (op)
         bdeq_pkg::OP_PUSH_FRONT: begin
            if (full) begin
               status_in = bdeq_pkg::ST_FULL;
            end else begin
               head_in  = head_dec;
               wr_req   = 1'b1;
               wr_addr  = head_dec;
               count_in = count_ff + 1'b1;
            end
         end
         bdeq_pkg::OP_PUSH_REAR: begin
            if (full) begin
               status_in = bdeq_pkg::ST_FULL;
            end else begin
               wr_req   = 1'b1;
               wr_addr  = rear_next;
               count_in = count_ff + 1'b1;
            end
         end
         bdeq_pkg::OP_POP_FRONT: begin
            if (empty) begin
               status_in = bdeq_pkg::ST_EMPTY;
            end else begin
               pop_ok_in = 1'b1;
               rd_addr   = head_ff;
               head_in   = head_inc;
               count_in  = count_ff - 1'b1;
            end
         end
         bdeq_pkg::OP_POP_REAR: begin
            if (empty) begin
               status_in = bdeq_pkg::ST_EMPTY;
            end else begin
               pop_ok_in = 1'b1;
               rd_addr   = rear_last;
               count_in  = count_ff - 1'b1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.load) begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         status_ff <= status_in;
         pop_ok_ff <= pop_ok_in;
      end
   end

   bdeq_ram #(
      .WIDTH (bdeq_pkg::WORD_W),
      .DEPTH (bdeq_pkg::DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (cmd.load && wr_req),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_popped    = (cmd.respond && pop_ok_ff) ? $signed(rd_data) : '0;
   assign rsp_status    = status_ff;
   assign rsp_occupancy = bdeq_pkg::OCC_W'(count_ff);

`ifndef SYNTHESIS
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= bdeq_pkg::CNT_W'(bdeq_pkg::DEPTH))
      else $error("element count exceeds capacity");

   a_reject_keeps_state: assert property (@(posedge clock) disable iff (reset)
      cmd.load && (status_in != bdeq_pkg::ST_DONE) |=> $stable(count_ff) && $stable(head_ff))
      else $error("rejected operation changed the deque");

   a_pop_ok_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.load && pop_ok_in |=> count_ff == $past(count_ff) - 1'b1)
      else $error("successful pop did not decrement the count");
`endif

endmodule

>>> tb/bounded_double_ended_queue_test.sv
// Expected response of the deque for one transaction.
typedef struct {
   logic signed [bdeq_pkg::WORD_W-1:0] popped;
   bdeq_pkg::status_type               status;
   logic [bdeq_pkg::OCC_W-1:0]         occupancy;
} deque_response_type;

// Tracks the deque contents and holds the responses that are still owed by the block.
class deque_tracker_type;
   logic signed [bdeq_pkg::WORD_W-1:0] held_words [bdeq_pkg::DEPTH];
   int                                 front_slot;
   int                                 word_count;
   deque_response_type                 owed_responses[$];
   int                                 mismatches;

   function new();
      front_slot = 0;
      word_count = 0;
      mismatches = 0;
   endfunction

   function int owed();
      return owed_responses.size();
   endfunction

   // Applies one accepted operation to the tracked contents and queues its response.
   function void note_request(bdeq_pkg::op_type op, logic signed [bdeq_pkg::WORD_W-1:0] word);
      deque_response_type rsp;
      int                 slot;
      rsp.popped = '0;
      rsp.status = bdeq_pkg::ST_DONE;
      case (op)
         bdeq_pkg::OP_PUSH_FRONT, bdeq_pkg::OP_PUSH_REAR: begin
            if (word_count >= bdeq_pkg::DEPTH) begin
               rsp.status = bdeq_pkg::ST_FULL;
            end else if (op == bdeq_pkg::OP_PUSH_FRONT) begin
               front_slot = (front_slot + bdeq_pkg::DEPTH - 1) % bdeq_pkg::DEPTH;
               held_words[front_slot] = word;
               word_count++;
            end else begin
               slot = (front_slot + word_count) % bdeq_pkg::DEPTH;
               held_words[slot] = word;
               word_count++;
            end
         end
         default: begin
            if (word_count == 0) begin
               rsp.status = bdeq_pkg::ST_EMPTY;
            end else if (op == bdeq_pkg::OP_POP_FRONT) begin
               rsp.popped = held_words[front_slot];
               front_slot = (front_slot + 1) % bdeq_pkg::DEPTH;
               word_count--;
            end else begin
               slot = (front_slot + word_count - 1) % bdeq_pkg::DEPTH;
               rsp.popped = held_words[slot];
               word_count--;
            end
         end
      endcase
      rsp.occupancy = bdeq_pkg::OCC_W'(word_count);
      owed_responses.push_back(rsp);
   endfunction

   // Compares one strobed response with the oldest one owed.
   function void check_response(logic signed [bdeq_pkg::WORD_W-1:0] popped,
                                logic [1:0] status, logic [bdeq_pkg::OCC_W-1:0] occupancy);
      deque_response_type want;
      if (owed_responses.size() == 0) begin
         $error("response strobed with none owed: popped %0d status %0d occupancy %0d",
                popped, status, occupancy);
         mismatches++;
         return;
      end
      want = owed_responses.pop_front();
      if (popped !== want.popped) begin
         $error("popped: expected %0d, actual %0d", want.popped, popped);
         mismatches++;
      end
      if (status !== want.status) begin
         $error("status: expected %0d, actual %0d", want.status, status);
         mismatches++;
      end
      if (occupancy !== want.occupancy) begin
         $error("occupancy: expected %0d, actual %0d", want.occupancy, occupancy);
         mismatches++;
      end
   endfunction
endclass

module bounded_double_ended_queue_test;
   timeunit 1ns;
   timeprecision 1ps;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               start = 1'b0;
   logic                               busy;
   logic [1:0]                         req_func = bdeq_pkg::OP_PUSH_FRONT;
   logic signed [bdeq_pkg::WORD_W-1:0] req_value = '0;
   logic                               rsp_strobe;
   logic signed [bdeq_pkg::WORD_W-1:0] rsp_popped;
   logic [1:0]                         rsp_status;
   logic [bdeq_pkg::OCC_W-1:0]         rsp_occupancy;

   // Percent chance, per cycle, that the sender holds off before its next transaction.
   int unsigned       gap_percent = 6;
   deque_tracker_type tracker = new();

   bounded_double_ended_queue DUT (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_func      (req_func),
      .req_value     (req_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_popped    (rsp_popped),
      .rsp_status    (rsp_status),
      .rsp_occupancy (rsp_occupancy)
   );

   always #5 clock = ~clock;

   // Everything is observed at the rising edge, where the values that the block registers
   // are still the ones from the cycle that is ending. A response is checked before the
   // transaction of the same edge is noted, since it always belongs to an earlier one.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) begin
            tracker.check_response(rsp_popped, rsp_status, rsp_occupancy);
         end
         if (start && !busy) begin
            tracker.note_request(bdeq_pkg::op_type'(req_func), req_value);
         end
      end
   end

   // Drives one transaction and returns at the falling edge after it was accepted. The task
   // is entered at a falling edge and touches start only once per edge, so a start that
   // stays high from one transaction to the next is never dropped and raised in one step.
   task automatic issue(bdeq_pkg::op_type op, logic signed [bdeq_pkg::WORD_W-1:0] word);
      while ($urandom_range(99) < gap_percent) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start     <= 1'b1;
      req_func  <= op;
      req_value <= word;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   // Holds the sender back until the block has answered every transaction so far.
   task automatic wait_for_quiet();
      start <= 1'b0;
      do begin
         @(negedge clock);
      end while (tracker.owed() != 0);
   endtask

   // Picks a push with the given percent chance, else a pop, end and word at random.
   task automatic issue_random(int unsigned push_percent);
      bdeq_pkg::op_type op;
      if ($urandom_range(99) < push_percent) begin
         op = $urandom_range(1) ? bdeq_pkg::OP_PUSH_REAR : bdeq_pkg::OP_PUSH_FRONT;
      end else begin
         op = $urandom_range(1) ? bdeq_pkg::OP_POP_REAR : bdeq_pkg::OP_POP_FRONT;
      end
      issue(op, $urandom());
   endtask

   initial begin
      int unsigned push_bias [10];
      int          settle;

      push_bias = '{50, 85, 15, 95, 5, 60, 40, 90, 10, 50};

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: pops on the empty deque at both ends, the extreme words pushed at
      // both ends, and pops that take them out from each end until the deque runs dry.
      issue(bdeq_pkg::OP_POP_FRONT, 32'sd5);
      issue(bdeq_pkg::OP_POP_REAR, -32'sd5);
      issue(bdeq_pkg::OP_PUSH_FRONT, 32'sh7FFF_FFFF);
      issue(bdeq_pkg::OP_PUSH_REAR, 32'sh8000_0000);
      issue(bdeq_pkg::OP_PUSH_FRONT, -32'sd1);
      issue(bdeq_pkg::OP_PUSH_REAR, 32'sd0);
      issue(bdeq_pkg::OP_POP_FRONT, 32'sh5555_5555);
      issue(bdeq_pkg::OP_POP_REAR, 32'shAAAA_AAAA);
      issue(bdeq_pkg::OP_PUSH_FRONT, 32'sh1234_5678);
      issue(bdeq_pkg::OP_POP_REAR, 32'sd0);
      issue(bdeq_pkg::OP_POP_FRONT, 32'sd0);
      issue(bdeq_pkg::OP_POP_FRONT, 32'sd0);
      issue(bdeq_pkg::OP_POP_REAR, 32'sd0);

      // Fill the deque past its capacity so that pushes at both ends are turned away,
      // then empty it again past the bottom. Mixed ends make the head wrap around.
      for (int i = 0; i < bdeq_pkg::DEPTH + 4; i++) begin
         issue_random(100);
      end
      wait_for_quiet();
      for (int i = 0; i < bdeq_pkg::DEPTH + 4; i++) begin
         issue_random(0);
      end

      // Random phases with different push bias, so that the occupancy drifts between
      // empty and full many times. One phase runs with no gaps at all, and the sender
      // waits for every response halfway through.
      for (int phase = 0; phase < 10; phase++) begin
         gap_percent = (phase == 3) ? 0 : 6;
         if (phase == 5) begin
            wait_for_quiet();
         end
         for (int i = 0; i < 62; i++) begin
            issue_random(push_bias[phase]);
         end
      end

      // Wait for the last responses, then a few more cycles in case anything stray follows.
      start <= 1'b0;
      settle = 0;
      while (tracker.owed() != 0 && settle < 100) begin
         @(negedge clock);
         settle++;
      end
      if (tracker.owed() != 0) begin
         $error("%0d responses never arrived", tracker.owed());
         tracker.mismatches++;
      end
      repeat (4) @(negedge clock);

      if (tracker.mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // A hung handshake ends the run here; a correct run takes well under a tenth of this.
   initial begin
      #1ms;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
